[src/clmd_pkg.sv]
// ---------------------------------------------------------------------------
// clmd_pkg: shared types and constants for the cut list merge block
// Payload structs, command codes and default sizes.
// ---------------------------------------------------------------------------
package clmd_pkg;

    localparam int DefInCuts    = 16;
    localparam int DefOutCuts   = 32;
    localparam int DefNodeBits  = 16;
    localparam int DefLeafSlots = 4;

    localparam logic [1:0] CMD_LOAD_A  = 2'd0;
    localparam logic [1:0] CMD_LOAD_B  = 2'd1;
    localparam logic [1:0] CMD_COMPUTE = 2'd2;

    typedef struct packed {
        logic [1:0]  command;
        logic [2:0]  leaf_count;
        logic [15:0] leaf_first;
        logic [15:0] leaf_second;
        logic [15:0] leaf_third;
        logic [15:0] leaf_fourth;
        logic [15:0] root_node;
    } in_word_t;

    typedef struct packed {
        logic [2:0]  cut_size;
        logic [15:0] out_first;
        logic [15:0] out_second;
        logic [15:0] out_third;
        logic [15:0] out_fourth;
        logic        is_last;
        logic        dropped;
    } out_word_t;

endpackage

[src/clmd_merge.sv]
// ---------------------------------------------------------------------------
// clmd_merge: sorted merge of two cuts
// Two-pointer union of up to four plus four leaves, limited by lim.
// Combinational; at most eight dependent narrow steps.
// ---------------------------------------------------------------------------
module clmd_merge #(
    parameter int NODE_BITS  = clmd_pkg::DefNodeBits,
    parameter int LEAF_SLOTS = clmd_pkg::DefLeafSlots
) (
    input  logic [LEAF_SLOTS-1:0][NODE_BITS-1:0] x,
    input  logic [2:0]                           nx,
    input  logic [LEAF_SLOTS-1:0][NODE_BITS-1:0] y,
    input  logic [2:0]                           ny,
    input  logic [2:0]                           lim,
    output logic [LEAF_SLOTS-1:0][NODE_BITS-1:0] r,
    output logic [2:0]                           n,
    output logic                                 ok
);
    import clmd_pkg::*;

    // at most one output leaf per step
    always_comb
    begin
        logic [3:0] i, j, c;
        logic       fail;
        logic [NODE_BITS-1:0] xv, yv;
        i = '0;
        j = '0;
        c = '0;
        fail = 1'b0;
        xv = '0;
        yv = '0;
        r = '0;
        for (int s = 0; s < 2 * LEAF_SLOTS; s++) begin
            xv = (i < 4'(LEAF_SLOTS)) ? x[i[1:0]] : '0;
            yv = (j < 4'(LEAF_SLOTS)) ? y[j[1:0]] : '0;
            if (!fail && (i < {1'b0, nx} || j < {1'b0, ny})) begin
                if (c >= {1'b0, lim}) begin
                    fail = 1'b1;
                end else if (i < {1'b0, nx} && j < {1'b0, ny}) begin
                    if (xv == yv) begin
                        r[c[1:0]] = xv;
                        i = i + 4'd1;
                        j = j + 4'd1;
                    end else if (xv < yv) begin
                        r[c[1:0]] = xv;
                        i = i + 4'd1;
                    end else begin
                        r[c[1:0]] = yv;
                        j = j + 4'd1;
                    end
                    c = c + 4'd1;
                end else if (i < {1'b0, nx}) begin
                    r[c[1:0]] = xv;
                    i = i + 4'd1;
                    c = c + 4'd1;
                end else begin
                    r[c[1:0]] = yv;
                    j = j + 4'd1;
                    c = c + 4'd1;
                end
            end
        end
        n = c[2:0];
        ok = !fail && (c != 4'd0);
    end

endmodule

[src/cut_list_merge_dedup.sv]
// ---------------------------------------------------------------------------
// cut_list_merge_dedup: four-leaf cut enumeration for one AND node
// Loads fill two cut memories; compute merges all pairs, drops merges over the
// leaf limit, skips duplicates against a kept-cut memory, then streams the trivial cut and the kept cuts out.
// ---------------------------------------------------------------------------
// Sequence: a load is written when accepted. After a compute is accepted each
//   pair goes S_RDAB, S_MERGE, then S_CMP if the merge holds (one kept-cut
//   compare per cycle, cut short by a match), then S_NEXT; then the trivial
//   cut and each kept cut (read in S_RDE, sent in S_EMIT) go out, held while stalled.
// Throughput: one item at a time; loads are taken every cycle while idle.
// Reset: counts, flags and max_leaves (4) clear at once; memories need none.
module cut_list_merge_dedup #(
    parameter int IN_CUTS    = clmd_pkg::DefInCuts,
    parameter int OUT_CUTS   = clmd_pkg::DefOutCuts,
    parameter int NODE_BITS  = clmd_pkg::DefNodeBits,
    parameter int LEAF_SLOTS = clmd_pkg::DefLeafSlots
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  clmd_pkg::in_word_t  in_word,
    output logic                out_valid,
    input  logic                out_stall,
    output clmd_pkg::out_word_t out_word,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_data
);
    import clmd_pkg::*;

    localparam int IAW = (IN_CUTS > 1) ? $clog2(IN_CUTS) : 1;
    localparam int OAW = (OUT_CUTS > 1) ? $clog2(OUT_CUTS) : 1;
    localparam int ICW = $clog2(IN_CUTS + 1);
    localparam int OCW = $clog2(OUT_CUTS + 1);

    typedef logic [LEAF_SLOTS-1:0][NODE_BITS-1:0] cut_t;
    typedef struct packed {
        cut_t       leaves;
        logic [2:0] size;
    } entry_t;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_RDAB  = 8'b0000_0010,
        S_MERGE = 8'b0000_0100,
        S_CMP   = 8'b0000_1000,
        S_TRIV  = 8'b0001_0000,
        S_RDE   = 8'b0010_0000,
        S_EMIT  = 8'b0100_0000,
        S_NEXT  = 8'b1000_0000
    } state_t;

    // memories
    entry_t mem_a [IN_CUTS];
    entry_t mem_b [IN_CUTS];
    entry_t mem_e [OUT_CUTS];
    entry_t rd_a, rd_b, rd_e;

    state_t           state_reg, state_next;
    logic [2:0]       maxl_reg;
    logic [ICW-1:0]   cnt_a_reg, cnt_b_reg;
    logic [OCW-1:0]   cnt_e_reg;
    logic             lost_reg, drop_reg;
    logic [ICW-1:0]   ia_reg, ib_reg;
    logic [OCW-1:0]   k_reg;
    entry_t           cand_reg;
    logic [NODE_BITS-1:0] root_reg;
    out_word_t        out_reg;
    logic             ov_reg;

    logic match, last_pair, cmp_done, out_free, load_out;

    // address muxes; the kept-cut read runs one index ahead of the compare
    logic [IAW-1:0] ra_addr, rb_addr;
    logic [OAW-1:0] re_addr;
    logic [OCW-1:0] k_look;
    assign ra_addr = ia_reg[IAW-1:0];
    assign rb_addr = ib_reg[IAW-1:0];
    assign k_look = (state_reg == S_MERGE) ? '0 :
                    (state_reg == S_CMP && !cmp_done && !match) ? k_reg + OCW'(1) :
                    k_reg;
    assign re_addr = k_look[OAW-1:0];

    // load word
    entry_t load_e;
    logic [2:0] lc;
    cut_t in_leaves;
    always_comb
    begin
        lc = (in_word.leaf_count > 3'(LEAF_SLOTS)) ? 3'(LEAF_SLOTS) : in_word.leaf_count;
        in_leaves = '0;
        in_leaves[0] = NODE_BITS'(in_word.leaf_first);
        in_leaves[1] = NODE_BITS'(in_word.leaf_second);
        if (LEAF_SLOTS > 2) in_leaves[2 % LEAF_SLOTS] = NODE_BITS'(in_word.leaf_third);
        if (LEAF_SLOTS > 3) in_leaves[3 % LEAF_SLOTS] = NODE_BITS'(in_word.leaf_fourth);
        for (int m = 0; m < LEAF_SLOTS; m++)
            if (3'(m) >= lc) in_leaves[m] = '0;
        load_e.leaves = in_leaves;
        load_e.size = lc;
    end

    logic acc_in, idle;
    assign idle = (state_reg == S_IDLE);
    assign in_stall = !idle;
    assign acc_in = in_valid && idle;
    assign cfg_ready = idle;

    logic wr_a, wr_b, wr_e;
    assign wr_a = acc_in && in_word.command == CMD_LOAD_A && cnt_a_reg < ICW'(IN_CUTS);
    assign wr_b = acc_in && in_word.command == CMD_LOAD_B && cnt_b_reg < ICW'(IN_CUTS);

    always_ff @(posedge clk)
    begin
        if (wr_a) mem_a[cnt_a_reg[IAW-1:0]] <= load_e;
        if (wr_b) mem_b[cnt_b_reg[IAW-1:0]] <= load_e;
        if (wr_e) mem_e[cnt_e_reg[OAW-1:0]] <= cand_reg;
        rd_a <= mem_a[ra_addr];
        rd_b <= mem_b[rb_addr];
        rd_e <= mem_e[re_addr];
    end

    // merge unit
    logic [2:0] lim;
    cut_t       m_r;
    logic [2:0] m_n;
    logic       m_ok;
    assign lim = (maxl_reg > 3'(LEAF_SLOTS)) ? 3'(LEAF_SLOTS) : maxl_reg;

    clmd_merge #(.NODE_BITS(NODE_BITS), .LEAF_SLOTS(LEAF_SLOTS)) u_merge (
        .x(rd_a.leaves), .nx(rd_a.size), .y(rd_b.leaves), .ny(rd_b.size),
        .lim(lim), .r(m_r), .n(m_n), .ok(m_ok)
    );

    assign match = (rd_e.size == cand_reg.size) && (rd_e.leaves == cand_reg.leaves);
    assign cmp_done = (k_reg >= cnt_e_reg);
    assign last_pair = (ib_reg + ICW'(1) >= cnt_b_reg) && (ia_reg + ICW'(1) >= cnt_a_reg);
    assign out_free = !ov_reg || !out_stall;
    assign load_out = out_free && (state_reg == S_TRIV || state_reg == S_EMIT);
    assign wr_e = (state_reg == S_CMP) && cmp_done && cnt_e_reg < OCW'(OUT_CUTS);

    // output word from a kept cut
    out_word_t emit_w;
    always_comb
    begin
        emit_w = '0;
        emit_w.cut_size = rd_e.size;
        emit_w.out_first = 16'(rd_e.leaves[0]);
        emit_w.out_second = 16'(rd_e.leaves[1]);
        if (LEAF_SLOTS > 2) emit_w.out_third = 16'(rd_e.leaves[2 % LEAF_SLOTS]);
        if (LEAF_SLOTS > 3) emit_w.out_fourth = 16'(rd_e.leaves[3 % LEAF_SLOTS]);
        emit_w.is_last = (k_reg + OCW'(1) == cnt_e_reg);
        emit_w.dropped = drop_reg;
    end

    // output word for the trivial cut
    out_word_t triv_w;
    always_comb
    begin
        triv_w = '0;
        triv_w.cut_size = 3'd1;
        triv_w.out_first = 16'(root_reg);
        triv_w.is_last = (cnt_e_reg == '0);
        triv_w.dropped = drop_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (acc_in && in_word.command == CMD_COMPUTE)
                    state_next = (cnt_a_reg == '0 || cnt_b_reg == '0) ? S_TRIV : S_RDAB;
            S_RDAB:  state_next = S_MERGE;
            S_MERGE: state_next = m_ok ? S_CMP : S_NEXT;
            S_CMP:   state_next = (cmp_done || match) ? S_NEXT : S_CMP;
            S_NEXT:  state_next = last_pair ? S_TRIV : S_RDAB;
            S_TRIV:  if (out_free) state_next = (cnt_e_reg == '0) ? S_IDLE : S_RDE;
            S_RDE:   state_next = S_EMIT;
            S_EMIT:  if (out_free) state_next = emit_w.is_last ? S_IDLE : S_RDE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
            maxl_reg <= 3'd4;
            cnt_a_reg <= '0;
            cnt_b_reg <= '0;
            cnt_e_reg <= '0;
            lost_reg <= 1'b0;
            drop_reg <= 1'b0;
            ia_reg <= '0;
            ib_reg <= '0;
            k_reg <= '0;
            ov_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (load_out) ov_reg <= 1'b1;
            else if (!out_stall) ov_reg <= 1'b0;
            if (cfg_valid && cfg_ready) maxl_reg <= cfg_data;
            unique case (state_reg)
                S_IDLE:
                    if (acc_in) begin
                        if (wr_a) cnt_a_reg <= cnt_a_reg + ICW'(1);
                        if (wr_b) cnt_b_reg <= cnt_b_reg + ICW'(1);
                        if ((in_word.command == CMD_LOAD_A && !wr_a) ||
                            (in_word.command == CMD_LOAD_B && !wr_b))
                            lost_reg <= 1'b1;
                        if (in_word.command == CMD_COMPUTE) begin
                            drop_reg <= lost_reg;
                            cnt_e_reg <= '0;
                            ia_reg <= '0;
                            ib_reg <= '0;
                        end
                    end
                S_RDAB: ;
                S_MERGE:
                    begin
                        k_reg <= '0;
                    end
                S_CMP:
                    if (cmp_done) begin
                        if (wr_e) cnt_e_reg <= cnt_e_reg + OCW'(1);
                        else drop_reg <= 1'b1;
                    end else if (!match) begin
                        k_reg <= k_reg + OCW'(1);
                    end
                S_NEXT:
                    if (ib_reg + ICW'(1) >= cnt_b_reg) begin
                        ib_reg <= '0;
                        ia_reg <= ia_reg + ICW'(1);
                    end else begin
                        ib_reg <= ib_reg + ICW'(1);
                    end
                S_TRIV:
                    if (out_free) begin
                        k_reg <= '0;
                        cnt_a_reg <= '0;
                        cnt_b_reg <= '0;
                        lost_reg <= 1'b0;
                    end
                S_RDE: ;
                S_EMIT:
                    if (out_free) begin
                        k_reg <= k_reg + OCW'(1);
                    end
                default: ;
            endcase
        end
    end

    // candidate and output payload
    always_ff @(posedge clk)
    begin
        if (acc_in) root_reg <= NODE_BITS'(in_word.root_node);
        if (state_reg == S_MERGE) begin
            cand_reg.leaves <= m_r;
            cand_reg.size <= m_n;
        end
        if (state_reg == S_TRIV && out_free) begin
            out_reg <= triv_w;
        end else if (state_reg == S_EMIT && out_free) begin
            out_reg <= emit_w;
        end
    end

    assign out_valid = ov_reg;
    assign out_word = out_reg;

`ifndef SYNTHESIS
    a_kept_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_e_reg <= OCW'(OUT_CUTS)) else $error("kept count overflow");
    a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !idle |-> !(wr_a || wr_b)) else $error("load while busy");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg && out_stall |=> ov_reg && $stable(out_reg)) else $error("output lost");
    a_cmp_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CMP |-> k_reg <= cnt_e_reg) else $error("compare index past kept");
`endif

endmodule
